// ----- sv/cia_pkg.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator package
// Shared types, operation codes, constants and helper functions.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned LenW   = 28;
  localparam int unsigned PosW   = 31;
  localparam int unsigned SumW   = 32;
  localparam int unsigned IdentW = 24;
  localparam int unsigned DenW   = SumW + 1;
  localparam int unsigned ProdW  = 57;
  localparam int unsigned RemW   = 58;

  localparam int unsigned DivSteps = IdentW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [LenW-1:0]   IndelLimitReset = LenW'(50);
  localparam logic [24:0]       IdentScale2     = 25'd20000000;
  localparam logic [IdentW-1:0] IdentScale      = IdentW'(10000000);

  typedef enum logic [3:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } cigar_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } cia_state_e;

  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic load_en;
    logic div_en;
    logic out_load;
  } cia_cmd_t;

  typedef struct packed {
    logic last_op;
  } cia_status_t;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

endpackage

// ----- sv/cia_if.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator channel interfaces
// Valid/ready channels for the operation input and the result output.
// ----------------------------------------------------------------------------
interface cia_in_if;
  import cia_pkg::*;

  logic            valid;
  logic            ready;
  logic [3:0]      cigar_op;
  logic [LenW-1:0] op_length;
  logic            first_op;
  logic            last_op;
  logic [PosW-1:0] ref_start;

  modport source (output valid, output cigar_op, output op_length, output first_op,
                  output last_op, output ref_start, input ready);
  modport sink (input valid, input cigar_op, input op_length, input first_op,
                input last_op, input ref_start, output ready);
endinterface

interface cia_out_if;
  import cia_pkg::*;

  logic              valid;
  logic              ready;
  logic [SumW-1:0]   match_count;
  logic [SumW-1:0]   mismatch_count;
  logic [SumW-1:0]   large_indel_count;
  logic [SumW-1:0]   large_indel_bases;
  logic [SumW-1:0]   read_len;
  logic [SumW-1:0]   ref_end;
  logic [IdentW-1:0] identity_scaled;
  logic              ambiguous_error;

  modport source (output valid, output match_count, output mismatch_count,
                  output large_indel_count, output large_indel_bases,
                  output read_len, output ref_end, output identity_scaled,
                  output ambiguous_error, input ready);
  modport sink (input valid, input match_count, input mismatch_count,
                input large_indel_count, input large_indel_bases,
                input read_len, input ref_end, input identity_scaled,
                input ambiguous_error, output ready);
endinterface

// ----- sv/cia_datapath.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator datapath
// Saturating sums, the identity multiply and a restoring divider that
// produces one quotient bit per cycle, plus the result register.
// ----------------------------------------------------------------------------
module cia_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            indel_limit_we_i,
  input  logic [cia_pkg::LenW-1:0]        indel_limit_i,
  input  logic [3:0]                      cigar_op_i,
  input  logic [cia_pkg::LenW-1:0]        op_length_i,
  input  logic                            first_op_i,
  input  logic                            last_op_i,
  input  logic [cia_pkg::PosW-1:0]        ref_start_i,
  input  cia_pkg::cia_cmd_t               cmd_i,
  output cia_pkg::cia_status_t            status_o,
  output logic [cia_pkg::SumW-1:0]        match_count_o,
  output logic [cia_pkg::SumW-1:0]        mismatch_count_o,
  output logic [cia_pkg::SumW-1:0]        large_indel_count_o,
  output logic [cia_pkg::SumW-1:0]        large_indel_bases_o,
  output logic [cia_pkg::SumW-1:0]        read_len_o,
  output logic [cia_pkg::SumW-1:0]        ref_end_o,
  output logic [cia_pkg::IdentW-1:0]      identity_scaled_o,
  output logic                            ambiguous_error_o
);
  import cia_pkg::*;

  logic [LenW-1:0]   limit_q;
  logic [SumW-1:0]   match_q, match_d;
  logic [SumW-1:0]   mism_q, mism_d;
  logic [SumW-1:0]   bnum_q, bnum_d;
  logic [SumW-1:0]   blen_q, blen_d;
  logic [SumW-1:0]   qlen_q, qlen_d;
  logic [SumW-1:0]   end_q, end_d;
  logic              err_q, err_d;
  logic [ProdW-1:0]  prod_q;
  logic [RemW-1:0]   rem_q;
  logic [RemW-1:0]   dsh_q;
  logic [IdentW-1:0] quo_q;
  logic              zero_q;
  logic [DenW-1:0]   den;
  logic              ge;

  logic [SumW-1:0]   b_match, b_mism, b_bnum, b_blen, b_qlen, b_end;
  logic              b_err;
  logic [SumW-1:0]   len32;
  logic              short_indel;

  assign status_o.last_op = last_op_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= IndelLimitReset;
    end else if (indel_limit_we_i) begin
      limit_q <= indel_limit_i;
    end
  end

  always_comb begin
    if (first_op_i) begin
      b_match = '0;
      b_mism  = '0;
      b_bnum  = '0;
      b_blen  = '0;
      b_qlen  = '0;
      b_end   = SumW'(ref_start_i);
      b_err   = 1'b0;
    end else begin
      b_match = match_q;
      b_mism  = mism_q;
      b_bnum  = bnum_q;
      b_blen  = blen_q;
      b_qlen  = qlen_q;
      b_end   = end_q;
      b_err   = err_q;
    end
    len32       = SumW'(op_length_i);
    short_indel = op_length_i <= limit_q;
    match_d = b_match;
    mism_d  = b_mism;
    bnum_d  = b_bnum;
    blen_d  = b_blen;
    qlen_d  = b_qlen;
    end_d   = b_end;
    err_d   = b_err;
    unique case (cigar_op_i)
      OP_EQ: begin
        match_d = sat_add(b_match, len32);
        qlen_d  = sat_add(b_qlen, len32);
        end_d   = sat_add(b_end, len32);
      end
      OP_X: begin
        mism_d = sat_add(b_mism, len32);
        qlen_d = sat_add(b_qlen, len32);
        end_d  = sat_add(b_end, len32);
      end
      OP_I, OP_D: begin
        if (short_indel) begin
          mism_d = sat_add(b_mism, len32);
        end else begin
          bnum_d = sat_add(b_bnum, SumW'(1));
          blen_d = sat_add(b_blen, len32);
        end
        if (cigar_op_i == OP_I) begin
          qlen_d = sat_add(b_qlen, len32);
        end else begin
          end_d = sat_add(b_end, len32);
        end
      end
      OP_S, OP_H: begin
        qlen_d = sat_add(b_qlen, len32);
      end
      OP_M: begin
        err_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      mism_q  <= '0;
      bnum_q  <= '0;
      blen_q  <= '0;
      qlen_q  <= '0;
      end_q   <= '0;
      err_q   <= 1'b0;
    end else if (cmd_i.acc_en) begin
      match_q <= match_d;
      mism_q  <= mism_d;
      bnum_q  <= bnum_d;
      blen_q  <= blen_d;
      qlen_q  <= qlen_d;
      end_q   <= end_d;
      err_q   <= err_d;
    end
  end

  assign den = DenW'(match_q) + DenW'(mism_q);
  assign ge  = rem_q >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(IdentScale2) * ProdW'(match_q);
    end
    if (cmd_i.load_en) begin
      rem_q  <= RemW'(prod_q) + RemW'(den);
      dsh_q  <= RemW'({den, 1'b0}) << (DivSteps - 1);
      zero_q <= den == '0;
      quo_q  <= '0;
    end else if (cmd_i.div_en) begin
      rem_q <= ge ? rem_q - dsh_q : rem_q;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[IdentW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      match_count_o       <= match_q;
      mismatch_count_o    <= mism_q;
      large_indel_count_o <= bnum_q;
      large_indel_bases_o <= blen_q;
      read_len_o          <= qlen_q;
      ref_end_o           <= end_q;
      identity_scaled_o   <= zero_q ? '0 : quo_q;
      ambiguous_error_o   <= err_q;
    end
  end

  a_ident_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> identity_scaled_o <= IdentScale)
    else $error("identity above full scale");

  a_ident_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && match_q == '0) |=> identity_scaled_o == '0)
    else $error("identity nonzero without matches");

  a_limit_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    indel_limit_we_i |=> limit_q == $past(indel_limit_i))
    else $error("indel limit not taken on write");

endmodule

// ----- sv/cia_ctrl.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator controller
// Sequences accumulation, the identity multiply, the divider steps and the
// hand-off to the output register.
// ----------------------------------------------------------------------------
module cia_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cia_pkg::cia_status_t status_i,
  output cia_pkg::cia_cmd_t    cmd_o
);
  import cia_pkg::*;

  cia_state_e       state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && status_i.last_op) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cnt_d      = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.load_en = 1'b1;
        cnt_d         = CntW'(DivSteps - 1);
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        cnt_d        = cnt_q - CntW'(1);
      end
      ST_FIN: begin
        cmd_o.out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && status_i.last_op) |=> state_q == ST_MUL)
    else $error("last transaction did not start the identity computation");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_FIN)
    else $error("divider did not finish after its last step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  a_load_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |=> (state_q == ST_DIV && cnt_q == CntW'(DivSteps - 1)))
    else $error("divider not started with full step count");

endmodule

// ----- sv/cigar_identity_accumulator.sv -----
// A non-final operation is added to the sums; while idle, one may be accepted every cycle.
// A final operation then passes a multiply state, a load state, 24 restoring divider steps
// (one quotient bit each) and an output load state, which waits while a result is pending.
// Input is not accepted while the divider runs; a pending result does not block input while idle.
// Reset (rst_ni low, asynchronous) clears all sums, the error flag and the output valid,
// and sets indel_limit to 50.
// ----------------------------------------------------------------------------
// CIGAR identity accumulator
// Accumulates CIGAR operation statistics per alignment and reports the sums
// and the rounded match identity on the final operation.
// ----------------------------------------------------------------------------
module cigar_identity_accumulator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     indel_limit_we_i,
  input  logic [cia_pkg::LenW-1:0] indel_limit_i,
  cia_in_if.sink                   in_i,
  cia_out_if.source                out_o
);
  import cia_pkg::*;

  cia_cmd_t    cmd;
  cia_status_t status;

  cia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cia_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .indel_limit_we_i    (indel_limit_we_i),
    .indel_limit_i       (indel_limit_i),
    .cigar_op_i          (in_i.cigar_op),
    .op_length_i         (in_i.op_length),
    .first_op_i          (in_i.first_op),
    .last_op_i           (in_i.last_op),
    .ref_start_i         (in_i.ref_start),
    .cmd_i               (cmd),
    .status_o            (status),
    .match_count_o       (out_o.match_count),
    .mismatch_count_o    (out_o.mismatch_count),
    .large_indel_count_o (out_o.large_indel_count),
    .large_indel_bases_o (out_o.large_indel_bases),
    .read_len_o          (out_o.read_len),
    .ref_end_o           (out_o.ref_end),
    .identity_scaled_o   (out_o.identity_scaled),
    .ambiguous_error_o   (out_o.ambiguous_error)
  );

endmodule

// ----- bench/cia_checker.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator checker
// Watches the operation and result channels and the limit register port.
// It keeps its own per-alignment tallies, predicts each result transaction
// and compares it field by field. The failure count and the number of
// results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module cia_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cia_pkg::LenW-1:0] cfg_data_i,
  cia_in_if                        in_mon,
  cia_out_if                       out_mon,
  output int                       fail_count_o,
  output int                       outstanding_o
);
  import cia_pkg::*;

  typedef struct packed {
    logic [SumW-1:0]   match_count;
    logic [SumW-1:0]   mismatch_count;
    logic [SumW-1:0]   large_indel_count;
    logic [SumW-1:0]   large_indel_bases;
    logic [SumW-1:0]   read_len;
    logic [SumW-1:0]   ref_end;
    logic [IdentW-1:0] identity_scaled;
    logic              ambiguous_error;
  } alignment_tally_t;

  alignment_tally_t expected_tallies[$];

  logic [LenW-1:0] indel_limit_q;
  logic [SumW-1:0] match_sum;
  logic [SumW-1:0] mismatch_sum;
  logic [SumW-1:0] big_indel_num;
  logic [SumW-1:0] big_indel_sum;
  logic [SumW-1:0] query_sum;
  logic [SumW-1:0] ref_pos;
  logic            saw_ambiguous;
  int              fails;

  function automatic logic [SumW-1:0] clamp_add(input logic [SumW-1:0] a,
                                                 input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  function automatic logic [IdentW-1:0] identity_of(input logic [SumW-1:0] m,
                                                    input logic [SumW-1:0] x);
    logic [63:0] den;
    logic [63:0] quo;
    den = 64'(m) + 64'(x);
    if (den == 64'd0) begin
      return '0;
    end
    quo = (64'd2 * 64'(IdentScale) * 64'(m) + den) / (den << 1);
    return quo[IdentW-1:0];
  endfunction

  task automatic count_indel(input logic [SumW-1:0] len);
    if (len <= SumW'(indel_limit_q)) begin
      mismatch_sum = clamp_add(mismatch_sum, len);
    end else begin
      big_indel_num = clamp_add(big_indel_num, SumW'(1));
      big_indel_sum = clamp_add(big_indel_sum, len);
    end
  endtask

  task automatic accumulate_op(input logic [3:0] op, input logic [LenW-1:0] length,
                               input logic first, input logic last,
                               input logic [PosW-1:0] start);
    logic [SumW-1:0]  len;
    alignment_tally_t t;
    len = SumW'(length);
    if (first) begin
      match_sum     = '0;
      mismatch_sum  = '0;
      big_indel_num = '0;
      big_indel_sum = '0;
      query_sum     = '0;
      ref_pos       = SumW'(start);
      saw_ambiguous = 1'b0;
    end
    case (op)
      OP_EQ: begin
        match_sum = clamp_add(match_sum, len);
        query_sum = clamp_add(query_sum, len);
        ref_pos   = clamp_add(ref_pos, len);
      end
      OP_X: begin
        mismatch_sum = clamp_add(mismatch_sum, len);
        query_sum    = clamp_add(query_sum, len);
        ref_pos      = clamp_add(ref_pos, len);
      end
      OP_I: begin
        count_indel(len);
        query_sum = clamp_add(query_sum, len);
      end
      OP_D: begin
        count_indel(len);
        ref_pos = clamp_add(ref_pos, len);
      end
      OP_S, OP_H: begin
        query_sum = clamp_add(query_sum, len);
      end
      OP_M: begin
        saw_ambiguous = 1'b1;
      end
      default: begin
      end
    endcase
    if (last) begin
      t.match_count       = match_sum;
      t.mismatch_count    = mismatch_sum;
      t.large_indel_count = big_indel_num;
      t.large_indel_bases = big_indel_sum;
      t.read_len          = query_sum;
      t.ref_end           = ref_pos;
      t.identity_scaled   = identity_of(match_sum, mismatch_sum);
      t.ambiguous_error   = saw_ambiguous;
      expected_tallies.push_back(t);
    end
  endtask

  task automatic check_field(input string name, input logic [SumW-1:0] exp_v,
                             input logic [SumW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alignment_tally_t t;
    if (!rst_ni) begin
      indel_limit_q = IndelLimitReset;
      match_sum     = '0;
      mismatch_sum  = '0;
      big_indel_num = '0;
      big_indel_sum = '0;
      query_sum     = '0;
      ref_pos       = '0;
      saw_ambiguous = 1'b0;
      expected_tallies.delete();
      outstanding_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_tallies.size() == 0) begin
          $error("result transaction with no expected result");
          fails++;
        end else begin
          t = expected_tallies.pop_front();
          check_field("match_count", t.match_count, out_mon.match_count);
          check_field("mismatch_count", t.mismatch_count, out_mon.mismatch_count);
          check_field("large_indel_count", t.large_indel_count,
                      out_mon.large_indel_count);
          check_field("large_indel_bases", t.large_indel_bases,
                      out_mon.large_indel_bases);
          check_field("read_len", t.read_len, out_mon.read_len);
          check_field("ref_end", t.ref_end, out_mon.ref_end);
          check_field("identity_scaled", SumW'(t.identity_scaled),
                      SumW'(out_mon.identity_scaled));
          check_field("ambiguous_error", SumW'(t.ambiguous_error),
                      SumW'(out_mon.ambiguous_error));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        accumulate_op(in_mon.cigar_op, in_mon.op_length, in_mon.first_op,
                      in_mon.last_op, in_mon.ref_start);
      end
      if (cfg_we_i) begin
        indel_limit_q = cfg_data_i;
      end
      outstanding_o <= expected_tallies.size();
    end
    fail_count_o <= fails;
  end

endmodule

// ----- bench/cigar_identity_accumulator_test.sv -----
// ----------------------------------------------------------------------------
// CIGAR identity accumulator testbench
// Drives CIGAR operations through the valid/ready input channel, first a
// directed set and then random alignments under several indel limits, with
// random gaps and stalls on both channels and a long receiver hold-off.
// A checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module cigar_identity_accumulator_test;
  import cia_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 40;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [LenW-1:0] cfg_data;
  bit              quiet;
  int              hold_asks;
  int              fail_count;
  int              outstanding;

  cia_in_if  in_ch ();
  cia_out_if out_ch ();

  cigar_identity_accumulator dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .indel_limit_we_i (cfg_we),
    .indel_limit_i    (cfg_data),
    .in_i             (in_ch),
    .out_o            (out_ch)
  );

  cia_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_op(input logic [3:0] op, input logic [LenW-1:0] len,
                         input logic first, input logic last,
                         input logic [PosW-1:0] start);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 20) ? $urandom_range(1, 2) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cigar_op  <= op;
    in_ch.op_length <= len;
    in_ch.first_op  <= first;
    in_ch.last_op   <= last;
    in_ch.ref_start <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_indel_limit(input logic [LenW-1:0] value);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_alignment(inout int sent);
    int              n;
    bit              heavy;
    logic [3:0]      op;
    logic [LenW-1:0] len;
    logic            first;
    logic            last;
    logic [PosW-1:0] start;
    heavy = ($urandom_range(0, 39) == 0);
    n     = heavy ? $urandom_range(17, 24) : $urandom_range(1, 8);
    start = PosW'($urandom());
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: op = OP_I;
        1: op = OP_D;
        2: op = ($urandom_range(0, 1) != 0) ? OP_S : OP_H;
        3, 4, 5: op = OP_EQ;
        6, 7: op = OP_X;
        default: op = 4'($urandom());
      endcase
      if (heavy) begin
        op  = ($urandom_range(0, 3) == 0) ? OP_X : OP_EQ;
        len = ($urandom_range(0, 3) == 0) ? LenW'($urandom()) : '1;
      end else begin
        case ($urandom_range(0, 9))
          0: len = '0;
          1: len = '1;
          2, 3: len = LenW'($urandom());
          default: len = LenW'($urandom_range(0, 120));
        endcase
      end
      first = (i == 0);
      last  = (i == n - 1);
      if ($urandom_range(0, 99) < 8) begin
        first = 1'($urandom());
        last  = 1'($urandom());
      end
      send_op(op, len, first, last, start);
      start = PosW'($urandom());
    end
    sent += n;
  endtask

  task automatic run_random(input int count, input bit with_hold);
    int  sent;
    bit  held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if (with_hold && !held && sent >= count / 3) begin
        hold_asks <= hold_asks + 1;
        held = 1'b1;
      end
      send_alignment(sent);
    end
  endtask

  initial begin : result_sink
    int served;
    served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served = hold_asks;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 20);
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("[cigar_identity_accumulator] ERROR");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.cigar_op  = '0;
    in_ch.op_length = '0;
    in_ch.first_op  = 1'b0;
    in_ch.last_op   = 1'b0;
    in_ch.ref_start = '0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    quiet           = 1'b0;
    hold_asks       = 0;
    rst_n           = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_EQ, LenW'(100), 1'b1, 1'b0, '1);
    send_op(OP_X, LenW'(3), 1'b0, 1'b0, '0);
    send_op(OP_I, LenW'(50), 1'b0, 1'b0, '0);
    send_op(OP_D, LenW'(51), 1'b0, 1'b0, '0);
    send_op(OP_I, '0, 1'b0, 1'b0, '0);
    send_op(OP_S, LenW'(10), 1'b0, 1'b0, '0);
    send_op(OP_H, LenW'(5), 1'b0, 1'b0, '0);
    send_op(OP_N, LenW'(7), 1'b0, 1'b0, '0);
    send_op(OP_P, LenW'(2), 1'b0, 1'b0, '0);
    send_op(4'hF, '1, 1'b0, 1'b0, '1);
    send_op(4'h9, LenW'(1), 1'b0, 1'b0, '0);
    send_op(OP_EQ, LenW'(1), 1'b0, 1'b1, '0);
    send_op(OP_M, LenW'(5), 1'b1, 1'b1, PosW'(1000));
    send_op(OP_X, LenW'(7), 1'b0, 1'b1, '1);
    send_op(OP_EQ, '1, 1'b1, 1'b1, '0);
    send_op(OP_EQ, '1, 1'b1, 1'b0, '1);
    for (int i = 0; i < 6; i++) begin
      send_op(OP_EQ, '1, 1'b0, 1'b0, '0);
    end
    send_op(OP_I, '1, 1'b0, 1'b0, '0);
    send_op(OP_D, '1, 1'b0, 1'b1, '0);

    write_indel_limit('0);
    quiet <= 1'b1;
    run_random(150, 1'b0);
    wait_drained();
    quiet <= 1'b0;

    write_indel_limit('1);
    run_random(200, 1'b1);

    write_indel_limit(LenW'($urandom()));
    run_random(200, 1'b0);

    write_indel_limit(LenW'(1));
    run_random(200, 1'b0);

    write_indel_limit(LenW'($urandom_range(0, 100)));
    run_random(250, 1'b1);

    wait_drained();
    if (fail_count == 0 && outstanding == 0) begin
      $display("[cigar_identity_accumulator] OK");
    end else begin
      $display("[cigar_identity_accumulator] ERROR");
    end
    $finish;
  end

endmodule
